[hw/rtl/brf_pkg.sv]
// ----------------------------------------------------------------------------
// brf_pkg: shared types and constants of the byte ring FIFO with search
// Operation codes, payload structs and sizing of the ring and the pattern.
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

    localparam int CAPACITY    = 256;
    localparam int PTR_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int PATTERN_MAX = 8;
    localparam int PAT_IDX_W   = $clog2(PATTERN_MAX + 1);
    localparam int PAT_SEL_W   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int PAT_W       = 64;
    localparam int LEN_W       = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 64;
    localparam int IDX_OUT_W   = 8;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_FLUSH = 2'd2,
        MODE_FIND  = 2'd3
    } brf_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES  = 1'b0,
        CFG_PATTERN_LENGTH = 1'b1
    } brf_cfg_idx_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_in;
    } brf_item_t;

    typedef struct packed {
        logic                 ok;
        logic [7:0]           data_out;
        logic                 found;
        logic [IDX_OUT_W-1:0] found_index;
        logic [CNT_W-1:0]     bytes_available;
    } brf_result_t;

endpackage

`default_nettype wire

[hw/rtl/brf_if.sv]
// ----------------------------------------------------------------------------
// brf_in_if / brf_out_if: valid/ready channels of the byte ring FIFO
// One transfer moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface brf_in_if;
    logic               valid;
    logic               ready;
    brf_pkg::brf_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface brf_out_if;
    logic                 valid;
    logic                 ready;
    brf_pkg::brf_result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/brf_ram.sv]
// ----------------------------------------------------------------------------
// brf_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/byte_ring_fifo_with_search_top.sv]
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_search_top: circular byte FIFO with pattern search
//
// Items arrive on in_ch (mode, data_in); every item yields exactly one result
// on out_ch (ok, data_out, found, found_index, bytes_available). Pattern and
// pattern length are written through cfg_we / cfg_index / cfg_data; the user
// must write them only while idle, the block itself does not enforce it.
// Push and flush: result registered in the cycle after the transfer.
// Pop: the byte RAM read is registered, then ST_POP loads the result register.
// Find: each byte compare runs ST_FIND_RD then ST_FIND_CMP through one shared
// compare step; an empty FIFO is answered from idle; in_ch is not ready
// during the scan. A new item is taken while idle and the result register
// is empty or being drained in the same cycle; a stalled receiver holds the
// result and blocks further items. Reset empties the FIFO, sets pattern 0 and
// length 1; the byte RAM is not cleared, only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_with_search_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    brf_in_if.sink                                in_ch,
    brf_out_if.source                             out_ch,
    input  wire logic                             cfg_we,
    input  wire logic [brf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [brf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int PTR_W = brf_pkg::PTR_W;
    localparam int CNT_W = brf_pkg::CNT_W;
    localparam int SUM_W = CNT_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_FIND_RD,
        ST_FIND_CMP
    } state_t;

    state_t                          state_reg, state_next;
    logic [PTR_W-1:0]                write_pos_reg, write_pos_next;
    logic [PTR_W-1:0]                read_pos_reg, read_pos_next;
    logic [CNT_W-1:0]                fill_reg, fill_next;
    logic [PTR_W-1:0]                k_reg, k_next;
    logic [brf_pkg::PAT_IDX_W-1:0]   j_reg, j_next;
    logic [brf_pkg::PAT_IDX_W-1:0]   len_reg, len_next;
    logic [brf_pkg::PAT_W-1:0]       pattern_reg;
    logic [brf_pkg::LEN_W-1:0]       pattern_len_reg;
    logic                            out_valid_reg, out_valid_next;
    brf_pkg::brf_result_t            out_reg, out_next;

    logic                            in_xfer;
    logic                            ram_we;
    logic [PTR_W-1:0]                ram_raddr;
    logic [7:0]                      ram_rdata;
    logic [PTR_W-1:0]                search_addr;
    logic [SUM_W-1:0]                kj_sum;
    logic [7:0]                      pat_byte;
    logic [brf_pkg::PAT_IDX_W-1:0]   len_sat;
    brf_pkg::brf_mode_t              mode;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(brf_pkg::CAPACITY - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign mode        = brf_pkg::brf_mode_t'(in_ch.payload.mode);
    assign in_ch.ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ch.ready);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_reg;

    assign ram_we      = in_xfer && (mode == brf_pkg::MODE_PUSH)
                         && (fill_reg < CNT_W'(brf_pkg::CAPACITY));
    assign search_addr = read_pos_reg + k_reg + PTR_W'(j_reg);
    assign ram_raddr   = (state_reg == ST_FIND_RD) ? search_addr : read_pos_reg;
    assign kj_sum      = SUM_W'(k_reg) + SUM_W'(j_reg);
    assign pat_byte    = pattern_reg[8 * j_reg[brf_pkg::PAT_SEL_W-1:0] +: 8];

    always_comb
    begin
        if (pattern_len_reg == '0)
        begin
            len_sat = brf_pkg::PAT_IDX_W'(1);
        end
        else if (brf_pkg::PAT_IDX_W'(pattern_len_reg) > brf_pkg::PAT_IDX_W'(brf_pkg::PATTERN_MAX)
                 || pattern_len_reg > brf_pkg::LEN_W'(brf_pkg::PATTERN_MAX))
        begin
            len_sat = brf_pkg::PAT_IDX_W'(brf_pkg::PATTERN_MAX);
        end
        else
        begin
            len_sat = brf_pkg::PAT_IDX_W'(pattern_len_reg);
        end
    end

    brf_ram #(
        .WIDTH (8),
        .DEPTH (brf_pkg::CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (write_pos_reg),
        .wdata (in_ch.payload.data_in),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        write_pos_next = write_pos_reg;
        read_pos_next  = read_pos_reg;
        fill_next      = fill_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_next       = out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    out_next = '0;
                    unique case (mode)
                        brf_pkg::MODE_PUSH:
                        begin
                            if (ram_we)
                            begin
                                write_pos_next = ring_next(write_pos_reg);
                                fill_next      = fill_reg + CNT_W'(1);
                                out_next.ok    = 1'b1;
                            end
                            out_next.bytes_available = ram_we ? fill_reg + CNT_W'(1)
                                                              : fill_reg;
                            out_valid_next = 1'b1;
                        end
                        brf_pkg::MODE_POP:
                        begin
                            if (fill_reg != '0)
                            begin
                                fill_next = fill_reg - CNT_W'(1);
                                if (fill_reg == CNT_W'(1))
                                begin
                                    read_pos_next  = '0;
                                    write_pos_next = '0;
                                end
                                else
                                begin
                                    read_pos_next = ring_next(read_pos_reg);
                                end
                                state_next = ST_POP;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                            end
                        end
                        brf_pkg::MODE_FLUSH:
                        begin
                            read_pos_next  = '0;
                            write_pos_next = '0;
                            fill_next      = '0;
                            out_next.ok    = 1'b1;
                            out_valid_next = 1'b1;
                        end
                        brf_pkg::MODE_FIND:
                        begin
                            out_next.ok              = 1'b1;
                            out_next.bytes_available = fill_reg;
                            if (fill_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                k_next     = '0;
                                j_next     = '0;
                                len_next   = len_sat;
                                state_next = ST_FIND_RD;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                out_next.ok              = 1'b1;
                out_next.data_out        = ram_rdata;
                out_next.bytes_available = fill_reg;
                out_valid_next           = 1'b1;
                state_next               = ST_IDLE;
            end
            ST_FIND_RD:
            begin
                if ((j_reg == len_reg) || (kj_sum >= SUM_W'(fill_reg)))
                begin
                    out_next.found       = 1'b1;
                    out_next.found_index = brf_pkg::IDX_OUT_W'(k_reg);
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FIND_CMP;
                end
            end
            ST_FIND_CMP:
            begin
                if (ram_rdata == pat_byte)
                begin
                    j_next     = j_reg + brf_pkg::PAT_IDX_W'(1);
                    state_next = ST_FIND_RD;
                end
                else if (CNT_W'(k_reg) + CNT_W'(1) == fill_reg)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    k_next     = k_reg + PTR_W'(1);
                    j_next     = '0;
                    state_next = ST_FIND_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            write_pos_reg   <= '0;
            read_pos_reg    <= '0;
            fill_reg        <= '0;
            k_reg           <= '0;
            j_reg           <= '0;
            len_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
            pattern_reg     <= '0;
            pattern_len_reg <= brf_pkg::LEN_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            write_pos_reg <= write_pos_next;
            read_pos_reg  <= read_pos_next;
            fill_reg      <= fill_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            if (cfg_we)
            begin
                unique case (brf_pkg::brf_cfg_idx_t'(cfg_index))
                    brf_pkg::CFG_PATTERN_BYTES:
                    begin
                        pattern_reg <= cfg_data[brf_pkg::PAT_W-1:0];
                    end
                    brf_pkg::CFG_PATTERN_LENGTH:
                    begin
                        pattern_len_reg <= cfg_data[brf_pkg::LEN_W-1:0];
                    end
                    default:
                    begin
                        pattern_reg <= pattern_reg;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[test/byte_ring_fifo_with_search_chk.sv]
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_search_chk: result checker for the byte ring FIFO
// Watches the item and result channels and the register write port, keeps
// its own ring, positions, fill count and pattern, and computes the result
// of every accepted item. Results are matched in order, field by field.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_search_chk
    import brf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    brf_in_if                     in_ch,
    brf_out_if                    out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending,
    output int                    hits
);

    logic [7:0]       ring [CAPACITY];
    logic [PTR_W-1:0] rd_pos;
    logic [PTR_W-1:0] wr_pos;
    int unsigned      level;
    logic [PAT_W-1:0] pattern;
    logic [LEN_W-1:0] pattern_len;
    brf_result_t      pending_results [$];

    function automatic logic [PTR_W-1:0] ring_step(logic [PTR_W-1:0] p);
        return (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic brf_result_t fifo_apply(brf_item_t item);
        brf_result_t res;
        int unsigned len;
        int unsigned k;
        int unsigned j;
        bit          hit;
        res = '0;
        case (item.mode)
            MODE_PUSH:
                if (level < CAPACITY) begin
                    ring[wr_pos] = item.data_in;
                    wr_pos = ring_step(wr_pos);
                    level++;
                    res.ok = 1'b1;
                end
            MODE_POP:
                if (level > 0) begin
                    res.data_out = ring[rd_pos];
                    rd_pos = ring_step(rd_pos);
                    level--;
                    res.ok = 1'b1;
                    if (level == 0) begin
                        rd_pos = '0;
                        wr_pos = '0;
                    end
                end
            MODE_FLUSH: begin
                rd_pos = '0;
                wr_pos = '0;
                level  = 0;
                res.ok = 1'b1;
            end
            default: begin
                len = pattern_len;
                if (len == 0)
                    len = 1;
                if (len > PATTERN_MAX)
                    len = PATTERN_MAX;
                res.ok = 1'b1;
                for (k = 0; k < level && !res.found; k++) begin
                    hit = 1'b1;
                    for (j = 0; j < len && k + j < level; j++)
                        if (ring[(rd_pos + k + j) % CAPACITY] != pattern[8*j +: 8])
                            hit = 1'b0;
                    if (hit) begin
                        res.found       = 1'b1;
                        res.found_index = IDX_OUT_W'(k);
                    end
                end
            end
        endcase
        res.bytes_available = CNT_W'(level);
        return res;
    endfunction

    task automatic report(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin : monitor
        brf_result_t want;
        brf_result_t got;
        if (!rst_n) begin
            rd_pos      = '0;
            wr_pos      = '0;
            level       = 0;
            pattern     = '0;
            pattern_len = LEN_W'(1);
            errors      = 0;
            hits        = 0;
            pending_results.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.payload;
                if (pending_results.size() == 0) begin
                    $error("result transfer with no result pending");
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (want.found)
                        hits++;
                    report("ok", want.ok, got.ok);
                    report("data_out", want.data_out, got.data_out);
                    report("found", want.found, got.found);
                    report("found_index", want.found_index, got.found_index);
                    report("bytes_available", want.bytes_available,
                           got.bytes_available);
                end
            end
            if (in_ch.valid && in_ch.ready)
                pending_results.push_back(fifo_apply(in_ch.payload));
            if (cfg_we)
                case (cfg_index)
                    CFG_PATTERN_BYTES:  pattern = cfg_data[PAT_W-1:0];
                    CFG_PATTERN_LENGTH: pattern_len = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
        end
        pending = pending_results.size();
    end

endmodule

[test/tb_byte_ring_fifo_with_search_top.sv]
// ----------------------------------------------------------------------------
// tb_byte_ring_fifo_with_search_top: testbench of the byte ring FIFO
// Runs a directed opening on empty, single-byte and truncated-pattern cases,
// then random phases under several pattern settings: planted pattern runs,
// pushes into a full ring, pops from an empty one, flushes and wrapped
// positions, with random gaps on the item side and random result stalls.
// ----------------------------------------------------------------------------
module tb_byte_ring_fifo_with_search_top;

    import brf_pkg::*;

    localparam int LIMIT_CYCLES = 20_000_000;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 110;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int          chk_errors;
    int          chk_pending;
    int          chk_hits;
    int          cycles;
    int          items;
    int          level;
    int          plen;
    bit          steady;
    logic [63:0] pattern;

    brf_in_if  in_ch ();
    brf_out_if out_ch ();

    byte_ring_fifo_with_search_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    byte_ring_fifo_with_search_chk u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (chk_errors),
        .pending   (chk_pending),
        .hits      (chk_hits)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : result_pace
        int run_left;
        int stall_left;
        int r;
        out_ch.ready = 1'b0;
        run_left     = 0;
        stall_left   = 0;
        forever
        begin
            @(posedge clk);
            if (steady)
                out_ch.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (run_left > 0)
            begin
                out_ch.ready <= 1'b1;
                run_left--;
            end
            else
            begin
                run_left   = $urandom_range(1, 24);
                r          = $urandom_range(0, 99);
                stall_left = (r < 65) ? $urandom_range(1, 3) :
                             (r < 95) ? $urandom_range(4, 12) : $urandom_range(20, 60);
                out_ch.ready <= 1'b1;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_byte();
        int j;
        if ($urandom_range(0, 99) < 30)
            return 8'($urandom);
        j = $urandom_range(0, plen - 1);
        return pattern[8*j +: 8];
    endfunction

    task automatic issue(brf_mode_t mode, logic [7:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= brf_item_t'{mode: mode, data_in: data};
        do
            @(posedge clk);
        while (!in_ch.ready);
        case (mode)
            MODE_PUSH:  if (level < CAPACITY) level++;
            MODE_POP:   if (level > 0) level--;
            MODE_FLUSH: level = 0;
            default: ;
        endcase
        items++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(brf_cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_pattern(logic [63:0] value, logic [LEN_W-1:0] len);
        drain();
        write_reg(CFG_PATTERN_BYTES, value);
        write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(len));
        pattern = value;
        plen    = (len == 0) ? 1 : (len > PATTERN_MAX) ? PATTERN_MAX : int'(len);
    endtask

    task automatic pop_run(int most);
        repeat ($urandom_range(1, (most < 1) ? 1 : most))
            issue(MODE_POP, 8'($urandom));
    endtask

    initial
    begin : stimulus
        int               p;
        int               r;
        int               j;
        int               n;
        int               phase_start;
        int               phase_end;
        bit               burst_done;
        logic [63:0]      pv;
        logic [LEN_W-1:0] lv;
        logic [7:0]       b;

        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_PATTERN_BYTES;
        cfg_data      = '0;
        steady        = 1'b0;
        items         = 0;
        level         = 0;
        pattern       = '0;
        plen          = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(MODE_POP, 8'hFF);
        issue(MODE_FIND, 8'h00);
        issue(MODE_PUSH, 8'h00);
        issue(MODE_PUSH, 8'hFF);
        issue(MODE_FIND, 8'hFF);
        issue(MODE_POP, 8'h00);
        issue(MODE_FIND, 8'h00);
        issue(MODE_PUSH, 8'h80);
        issue(MODE_PUSH, 8'h01);
        issue(MODE_POP, 8'h00);
        issue(MODE_POP, 8'h00);
        issue(MODE_POP, 8'h00);
        issue(MODE_POP, 8'h00);
        issue(MODE_PUSH, 8'h5A);
        issue(MODE_PUSH, 8'hA5);
        issue(MODE_FLUSH, 8'hFF);
        issue(MODE_FIND, 8'h00);
        issue(MODE_POP, 8'h00);
        issue(MODE_PUSH, 8'h3C);
        issue(MODE_POP, 8'h00);
        set_pattern('1, LEN_W'(8));
        repeat (3) issue(MODE_PUSH, 8'hFF);
        issue(MODE_FIND, 8'h00);
        issue(MODE_PUSH, 8'h00);
        issue(MODE_FIND, 8'h00);
        issue(MODE_FLUSH, 8'h00);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: begin pv = '0; lv = LEN_W'(0);  end
                1: begin pv = '1; lv = LEN_W'(15); end
                2: begin pv = '0; lv = LEN_W'(8);  end
                3: begin pv = '1; lv = LEN_W'(1);  end
                default:
                begin
                    pv = {$urandom, $urandom};
                    lv = LEN_W'($urandom_range(0, 15));
                end
            endcase
            set_pattern(pv, lv);
            steady      = (p % 4 == 2);
            burst_done  = !(p == 1 || p == 6);
            phase_start = items;
            phase_end   = 26 + (p + 1) * PHASE_ITEMS;
            while (items < phase_end)
            begin
                r = $urandom_range(0, 99);
                if (!burst_done && items > phase_start + 30)
                begin
                    while (level < CAPACITY)
                        issue(MODE_PUSH, pick_byte());
                    repeat ($urandom_range(1, 3)) issue(MODE_PUSH, 8'($urandom));
                    issue(MODE_FIND, 8'($urandom));
                    repeat (20) issue(MODE_POP, 8'($urandom));
                    repeat (12) issue(MODE_PUSH, pick_byte());
                    issue(MODE_FIND, 8'($urandom));
                    issue(MODE_FLUSH, 8'($urandom));
                    burst_done = 1'b1;
                end
                else if (level > 40 && r < 60)
                    pop_run(8);
                else if (r < 40)
                begin
                    j = ($urandom_range(0, 99) < 60) ? 0 : $urandom_range(0, plen - 1);
                    n = $urandom_range(1, plen);
                    for (int i = 0; i < n && j + i < plen; i++)
                    begin
                        b = pattern[8*(j+i) +: 8];
                        if ($urandom_range(0, 99) < 8)
                            b = b ^ 8'($urandom_range(1, 255));
                        issue(MODE_PUSH, b);
                    end
                    if ($urandom_range(0, 1))
                        issue(MODE_FIND, 8'($urandom));
                end
                else if (r < 55)
                    issue(MODE_PUSH, pick_byte());
                else if (r < 70)
                    issue(MODE_POP, 8'($urandom));
                else if (r < 85)
                    issue(MODE_FIND, 8'($urandom));
                else if (r < 88)
                    issue(MODE_FLUSH, 8'($urandom));
                else if (r < 95)
                    pop_run(level - 1);
                else
                    issue(MODE_PUSH, 8'($urandom));
            end
        end

        drain();
        repeat (16) @(posedge clk);
        $display("Ran %0d operations over %0d pattern settings, %0d finds with a match.",
                 items, NUM_PHASES + 2, chk_hits);
        $display("Covered full and empty ring, flushes, wrapped positions, lengths 0 to 15.");
        if (chk_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/brf_pkg.sv
hw/rtl/brf_if.sv
hw/rtl/brf_ram.sv
hw/rtl/byte_ring_fifo_with_search_top.sv
test/byte_ring_fifo_with_search_chk.sv
test/tb_byte_ring_fifo_with_search_top.sv
